// ----- hdl/displacement_to_normal_map_macros.svh -----
// Assertion helpers for the normal map checker
`ifndef DISPLACEMENT_TO_NORMAL_MAP_MACROS_SVH
`define DISPLACEMENT_TO_NORMAL_MAP_MACROS_SVH

// Same-cycle implication, off while reset is high
`define DNM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked through reset as well
`define DNM_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/dnm_pkg.sv -----
`timescale 1ns / 1ps

package dnm_pkg;

   // field and datapath widths
   localparam int DISP_W     = 16;
   localparam int STR_W      = 16;
   localparam int PROD_W     = 32;
   localparam int MAG_W      = 31;
   localparam int RAD_W      = 62;
   localparam int ROOT_W     = 31;
   localparam int SHIFT_W    = 5;
   localparam int NUM_W      = 47;
   localparam int QUOT_BITS  = 16;
   localparam int T_W        = 18;
   localparam int NORM_W     = 16;
   localparam int BYTE_W     = 8;
   localparam int LANES      = 3;
   localparam int FRAC_SHIFT = 15;
   localparam int TINY_SHIFT = 5;

   // pipeline depth
   localparam int SQRT_STEPS   = 31;
   localparam int FRONT_STAGES = 7;
   localparam int BACK_STAGES  = 3;
   localparam int DNM_LATENCY  = FRONT_STAGES + SQRT_STEPS + QUOT_BITS + BACK_STAGES;

   // fixed values
   localparam logic signed [STR_W-1:0]  STRENGTH_RESET = 16'sd256;
   localparam logic signed [PROD_W-1:0] ONE_Q20        = 32'sd1048576;
   localparam logic [RAD_W-1:0]         TINY_LIMIT     = 62'd1099511;
   localparam logic [T_W-1:0]           HALF_Q16       = 18'd32768;

   typedef struct packed {
      logic signed [DISP_W-1:0] disp_x;
      logic signed [DISP_W-1:0] disp_y;
      logic signed [DISP_W-1:0] disp_z;
      logic                     frame_end;
   } dnm_req_type;

   typedef struct packed {
      logic [NORM_W-1:0] normal_x;
      logic [NORM_W-1:0] normal_y;
      logic [NORM_W-1:0] normal_z;
      logic [BYTE_W-1:0] red_byte;
      logic [BYTE_W-1:0] green_byte;
      logic [BYTE_W-1:0] blue_byte;
      logic              last_pixel;
   } dnm_rsp_type;

   // what a pixel still needs once its quotients are known
   typedef struct packed {
      logic [LANES-1:0]          neg;
      logic                      tiny;
      logic [LANES-1:0][T_W-1:0] tiny_t;
      logic                      last;
   } dnm_tail_type;

   // what travels beside the length computation
   typedef struct packed {
      logic [LANES-1:0][MAG_W-1:0] mag;
      logic [SHIFT_W-1:0]          shift;
      dnm_tail_type                tail;
   } dnm_side_type;

endpackage

// ----- hdl/dnm_isqrt.sv -----
`timescale 1ns / 1ps

module dnm_isqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [dnm_pkg::RAD_W-1:0]       in_rad,
   input  dnm_pkg::dnm_side_type           in_side,
   output logic                            out_valid,
   output logic [dnm_pkg::ROOT_W-1:0]      out_root,
   output dnm_pkg::dnm_side_type           out_side
);
   import dnm_pkg::*;

   logic [SQRT_STEPS-1:0] valid_ff;
   logic [RAD_W-1:0]      rem_ff  [SQRT_STEPS];
   logic [RAD_W-1:0]      rem_in  [SQRT_STEPS];
   logic [RAD_W-1:0]      root_ff [SQRT_STEPS];
   logic [RAD_W-1:0]      root_in [SQRT_STEPS];
   dnm_side_type          side_ff [SQRT_STEPS];

   // one root bit per stage: try the weight, keep it if the remainder covers it
   always_comb begin
      logic [RAD_W-1:0] rem_p;
      logic [RAD_W-1:0] root_p;
      logic [RAD_W-1:0] weight;
      logic [RAD_W-1:0] trial;
      logic             take;
      for (int i = 0; i < SQRT_STEPS; i++) begin
         if (i == 0) begin
            rem_p  = in_rad;
            root_p = '0;
         end else begin
            rem_p  = rem_ff[i-1];
            root_p = root_ff[i-1];
         end
         weight     = RAD_W'(1) << (RAD_W - 2 - 2 * i);
         trial      = root_p + weight;
         take       = (rem_p >= trial);
         rem_in[i]  = take ? rem_p - trial : rem_p;
         root_in[i] = take ? (root_p >> 1) + weight : (root_p >> 1);
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[SQRT_STEPS-2:0], in_valid};
      end
   end

   // advance data
   always_ff @(posedge clock) begin
      for (int i = 0; i < SQRT_STEPS; i++) begin
         rem_ff[i]  <= rem_in[i];
         root_ff[i] <= root_in[i];
      end
      side_ff[0] <= in_side;
      for (int i = 1; i < SQRT_STEPS; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS-1];
   assign out_root  = root_ff[SQRT_STEPS-1][ROOT_W-1:0];
   assign out_side  = side_ff[SQRT_STEPS-1];

endmodule

// ----- hdl/dnm_div.sv -----
`timescale 1ns / 1ps

module dnm_div (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 in_valid,
   input  logic [dnm_pkg::ROOT_W-1:0]                           in_div,
   input  logic [dnm_pkg::LANES-1:0][dnm_pkg::NUM_W-1:0]        in_num,
   input  dnm_pkg::dnm_tail_type                                in_tail,
   output logic                                                 out_valid,
   output logic [dnm_pkg::LANES-1:0][dnm_pkg::QUOT_BITS-1:0]    out_quot,
   output dnm_pkg::dnm_tail_type                                out_tail
);
   import dnm_pkg::*;

   logic [QUOT_BITS-1:0]                 valid_ff;
   logic [LANES-1:0][NUM_W-1:0]          rem_ff  [QUOT_BITS];
   logic [LANES-1:0][NUM_W-1:0]          rem_in  [QUOT_BITS];
   logic [LANES-1:0][QUOT_BITS-1:0]      quot_ff [QUOT_BITS];
   logic [LANES-1:0][QUOT_BITS-1:0]      quot_in [QUOT_BITS];
   logic [ROOT_W-1:0]                    div_ff  [QUOT_BITS];
   dnm_tail_type                         tail_ff [QUOT_BITS];

   // restoring division, one quotient bit per stage, three lanes share the divisor
   always_comb begin
      logic [LANES-1:0][NUM_W-1:0]     rem_p;
      logic [LANES-1:0][QUOT_BITS-1:0] quot_p;
      logic [ROOT_W-1:0]               div_p;
      logic [NUM_W-1:0]                sub;
      for (int i = 0; i < QUOT_BITS; i++) begin
         if (i == 0) begin
            rem_p  = in_num;
            quot_p = '0;
            div_p  = in_div;
         end else begin
            rem_p  = rem_ff[i-1];
            quot_p = quot_ff[i-1];
            div_p  = div_ff[i-1];
         end
         sub = NUM_W'(div_p) << (QUOT_BITS - 1 - i);
         for (int l = 0; l < LANES; l++) begin
            quot_in[i][l] = quot_p[l];
            if (rem_p[l] >= sub) begin
               rem_in[i][l]                      = rem_p[l] - sub;
               quot_in[i][l][QUOT_BITS - 1 - i] = 1'b1;
            end else begin
               rem_in[i][l] = rem_p[l];
            end
         end
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[QUOT_BITS-2:0], in_valid};
      end
   end

   // advance data
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUOT_BITS; i++) begin
         rem_ff[i]  <= rem_in[i];
         quot_ff[i] <= quot_in[i];
      end
      div_ff[0]  <= in_div;
      tail_ff[0] <= in_tail;
      for (int i = 1; i < QUOT_BITS; i++) begin
         div_ff[i]  <= div_ff[i-1];
         tail_ff[i] <= tail_ff[i-1];
      end
   end

   assign out_valid = valid_ff[QUOT_BITS-1];
   assign out_quot  = quot_ff[QUOT_BITS-1];
   assign out_tail  = tail_ff[QUOT_BITS-1];

endmodule

// ----- hdl/displacement_to_normal_map.sv -----
// Pipeline: a result strobe follows its start transfer through the 31-stage square root
// and the 16-stage divider plus 10 stages of scaling and output.
// Throughput: one pixel per cycle while busy is low, that is outside reset; the receiver cannot stall.
// Reset (synchronous, active high) clears every valid bit, sets strength to 1.0
// and holds busy high while it lasts; no other wait exists.
`timescale 1ns / 1ps

module displacement_to_normal_map (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  dnm_pkg::dnm_req_type          req_data,
   output logic                          rsp_valid,
   output dnm_pkg::dnm_rsp_type          rsp_data,
   input  logic                          csr_we,
   input  logic [dnm_pkg::STR_W-1:0]     csr_wdata
);
   import dnm_pkg::*;

   logic signed [STR_W-1:0]   strength_ff;
   logic                      req_transfer;

   logic                      p1_valid_ff;
   logic signed [PROD_W-1:0]  p1_prod_ff [LANES];
   logic                      p1_last_ff;

   logic                      p2_valid_ff;
   logic signed [PROD_W-1:0]  p2_vec_ff [LANES];
   logic                      p2_last_ff;

   logic                      p3_valid_ff;
   dnm_side_type              p3_side_in;
   dnm_side_type              p3_side_ff;

   logic                      p4_valid_ff;
   logic [RAD_W-1:0]          p4_sq_ff [LANES];
   dnm_side_type              p4_side_ff;

   logic                      p5_valid_ff;
   logic [RAD_W-1:0]          p5_sum_ff;
   dnm_side_type              p5_side_ff;

   logic                      p6_valid_ff;
   logic [RAD_W-1:0]          p6_shift32;
   logic [RAD_W-1:0]          p6_rad_in;
   logic [RAD_W-1:0]          p6_rad_ff;
   dnm_side_type              p6_side_in;
   dnm_side_type              p6_side_ff;

   logic                      p7_valid_ff;
   logic [RAD_W-1:0]          p7_shift8;
   logic [RAD_W-1:0]          p7_shift4;
   logic [RAD_W-1:0]          p7_rad_in;
   logic [RAD_W-1:0]          p7_rad_ff;
   dnm_side_type              p7_side_in;
   dnm_side_type              p7_side_ff;

   logic                      sq_valid;
   logic [ROOT_W-1:0]         sq_root;
   dnm_side_type              sq_side;

   logic [5:0]                pn_shamt;
   logic                      pn_valid_ff;
   logic [LANES-1:0][NUM_W-1:0] pn_num_in;
   logic [LANES-1:0][NUM_W-1:0] pn_num_ff;
   logic [ROOT_W-1:0]         pn_div_ff;
   dnm_tail_type              pn_tail_ff;

   logic                      dv_valid;
   logic [LANES-1:0][QUOT_BITS-1:0] dv_quot;
   dnm_tail_type              dv_tail;

   logic                      pt_valid_ff;
   logic [LANES-1:0][T_W-1:0] pt_t_in;
   logic [LANES-1:0][T_W-1:0] pt_t_ff;
   logic                      pt_last_ff;

   logic [NORM_W-1:0]         norm_in [LANES];
   logic [BYTE_W-1:0]         byte_in [LANES];
   logic                      rsp_valid_ff;
   dnm_rsp_type               rsp_data_in;
   dnm_rsp_type               rsp_data_ff;

   // accept every cycle outside reset
   assign busy         = reset;
   assign req_transfer = start && !busy;

   // hold the strength register
   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff <= STRENGTH_RESET;
      end else if (csr_we) begin
         strength_ff <= signed'(csr_wdata);
      end
   end

   // advance valid bits through the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
         p5_valid_ff <= 1'b0;
         p6_valid_ff <= 1'b0;
         p7_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= req_transfer;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
         p5_valid_ff <= p4_valid_ff;
         p6_valid_ff <= p5_valid_ff;
         p7_valid_ff <= p6_valid_ff;
      end
   end

   // scale each component by strength
   always_ff @(posedge clock) begin
      p1_prod_ff[0] <= req_data.disp_x * strength_ff;
      p1_prod_ff[1] <= req_data.disp_y * strength_ff;
      p1_prod_ff[2] <= req_data.disp_z * strength_ff;
      p1_last_ff    <= req_data.frame_end;
   end

   // add one to z
   always_ff @(posedge clock) begin
      p2_vec_ff[0] <= p1_prod_ff[0];
      p2_vec_ff[1] <= p1_prod_ff[1];
      p2_vec_ff[2] <= p1_prod_ff[2] + ONE_Q20;
      p2_last_ff   <= p1_last_ff;
   end

   // split into sign and magnitude, and prepare the tiny-vector result
   always_comb begin
      p3_side_in = '0;
      for (int l = 0; l < LANES; l++) begin
         p3_side_in.tail.neg[l]    = p2_vec_ff[l][PROD_W-1];
         p3_side_in.mag[l]         = p2_vec_ff[l][PROD_W-1] ? MAG_W'(-p2_vec_ff[l])
                                                            : MAG_W'(p2_vec_ff[l]);
         p3_side_in.tail.tiny_t[l] = T_W'((p2_vec_ff[l] + ONE_Q20) >>> TINY_SHIFT);
      end
      p3_side_in.tail.last = p2_last_ff;
   end

   always_ff @(posedge clock) begin
      p3_side_ff <= p3_side_in;
   end

   // square each magnitude
   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         p4_sq_ff[l] <= p3_side_ff.mag[l] * p3_side_ff.mag[l];
      end
      p4_side_ff <= p3_side_ff;
   end

   // sum the squares
   always_ff @(posedge clock) begin
      p5_sum_ff  <= p4_sq_ff[0] + p4_sq_ff[1] + p4_sq_ff[2];
      p5_side_ff <= p4_side_ff;
   end

   // flag tiny vectors; normalize by 32 and 16 bit steps
   always_comb begin
      p6_side_in           = p5_side_ff;
      p6_side_in.tail.tiny = (p5_sum_ff <= TINY_LIMIT);
      p6_side_in.shift     = '0;
      p6_side_in.shift[4]  = (p5_sum_ff[RAD_W-1 -: 32] == '0);
      p6_shift32           = p6_side_in.shift[4] ? (p5_sum_ff << 32) : p5_sum_ff;
      p6_side_in.shift[3]  = (p6_shift32[RAD_W-1 -: 16] == '0);
      p6_rad_in            = p6_side_in.shift[3] ? (p6_shift32 << 16) : p6_shift32;
   end

   always_ff @(posedge clock) begin
      p6_rad_ff  <= p6_rad_in;
      p6_side_ff <= p6_side_in;
   end

   // finish normalizing by 8, 4 and 2 bit steps
   always_comb begin
      p7_side_in          = p6_side_ff;
      p7_side_in.shift[2] = (p6_rad_ff[RAD_W-1 -: 8] == '0);
      p7_shift8           = p7_side_in.shift[2] ? (p6_rad_ff << 8) : p6_rad_ff;
      p7_side_in.shift[1] = (p7_shift8[RAD_W-1 -: 4] == '0);
      p7_shift4           = p7_side_in.shift[1] ? (p7_shift8 << 4) : p7_shift8;
      p7_side_in.shift[0] = (p7_shift4[RAD_W-1 -: 2] == '0);
      p7_rad_in           = p7_side_in.shift[0] ? (p7_shift4 << 2) : p7_shift4;
   end

   always_ff @(posedge clock) begin
      p7_rad_ff  <= p7_rad_in;
      p7_side_ff <= p7_side_in;
   end

   // length of the normalized vector
   dnm_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p7_valid_ff),
      .in_rad    (p7_rad_ff),
      .in_side   (p7_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // line up each magnitude with the length for division
   assign pn_shamt = 6'(FRAC_SHIFT) + {1'b0, sq_side.shift};

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         pn_num_in[l] = {(NUM_W - MAG_W)'(0), sq_side.mag[l]} << pn_shamt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pn_valid_ff <= 1'b0;
      end else begin
         pn_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      pn_num_ff  <= pn_num_in;
      pn_div_ff  <= sq_root;
      pn_tail_ff <= sq_side.tail;
   end

   dnm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pn_valid_ff),
      .in_div    (pn_div_ff),
      .in_num    (pn_num_ff),
      .in_tail   (pn_tail_ff),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_tail  (dv_tail)
   );

   // map each unit component to 0.5*n+0.5, or take the tiny-vector value
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (dv_tail.tiny) begin
            pt_t_in[l] = dv_tail.tiny_t[l];
         end else if (dv_tail.neg[l]) begin
            pt_t_in[l] = HALF_Q16 - T_W'(dv_quot[l]);
         end else begin
            pt_t_in[l] = HALF_Q16 + T_W'(dv_quot[l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_valid_ff <= 1'b0;
      end else begin
         pt_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      pt_t_ff    <= pt_t_in;
      pt_last_ff <= dv_tail.last;
   end

   // saturate to Q0.16 and scale to a byte
   always_comb begin
      logic [T_W-2:0]       t_mag;
      logic [T_W+BYTE_W-2:0] scaled;
      logic [BYTE_W:0]      byte_wide;
      for (int l = 0; l < LANES; l++) begin
         t_mag     = pt_t_ff[l][T_W-2:0];
         scaled    = {t_mag, BYTE_W'(0)} - {BYTE_W'(0), t_mag};
         byte_wide = scaled[T_W+BYTE_W-2 -: BYTE_W+1];
         if (pt_t_ff[l][T_W-1]) begin
            norm_in[l] = '0;
            byte_in[l] = '0;
         end else begin
            norm_in[l] = pt_t_ff[l][NORM_W] ? '1 : pt_t_ff[l][NORM_W-1:0];
            byte_in[l] = byte_wide[BYTE_W] ? '1 : byte_wide[BYTE_W-1:0];
         end
      end
      rsp_data_in.normal_x   = norm_in[0];
      rsp_data_in.normal_y   = norm_in[1];
      rsp_data_in.normal_z   = norm_in[2];
      rsp_data_in.red_byte   = byte_in[0];
      rsp_data_in.green_byte = byte_in[1];
      rsp_data_in.blue_byte  = byte_in[2];
      rsp_data_in.last_pixel = pt_last_ff;
   end

   // drive the result strobe for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= pt_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hdl/dnm_checker.sv -----
`timescale 1ns / 1ps
`include "displacement_to_normal_map_macros.svh"

module dnm_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input dnm_pkg::dnm_req_type  req_data,
   input logic                  rsp_valid,
   input dnm_pkg::dnm_rsp_type  rsp_data
);
   import dnm_pkg::*;

   logic [NORM_W+BYTE_W-1:0] scaled_x;
   logic [NORM_W+BYTE_W-1:0] scaled_y;
   logic [NORM_W+BYTE_W-1:0] scaled_z;
   logic                     bytes_ok;

   // below full scale, each byte is the Q0.16 value times 255, truncated
   always_comb begin
      scaled_x = rsp_data.normal_x * 8'd255;
      scaled_y = rsp_data.normal_y * 8'd255;
      scaled_z = rsp_data.normal_z * 8'd255;
      bytes_ok = (rsp_data.normal_x == '1 || rsp_data.red_byte == scaled_x[NORM_W+BYTE_W-1 -: BYTE_W])
              && (rsp_data.normal_y == '1 || rsp_data.green_byte == scaled_y[NORM_W+BYTE_W-1 -: BYTE_W])
              && (rsp_data.normal_z == '1 || rsp_data.blue_byte == scaled_z[NORM_W+BYTE_W-1 -: BYTE_W]);
   end

   `DNM_ASSERT_IMPLY(a_rsp_has_req, clock, reset, rsp_valid, $past(start && !busy, DNM_LATENCY), "result strobe without a request at the pipeline depth")
   `DNM_ASSERT_IMPLY(a_last_follows, clock, reset, rsp_valid, rsp_data.last_pixel == $past(req_data.frame_end, DNM_LATENCY), "last pixel mark out of step with its request")
   `DNM_ASSERT_IMPLY(a_bytes_match, clock, reset, rsp_valid, bytes_ok, "byte output disagrees with its Q0.16 value")
   `DNM_ASSERT_NEXT(a_reset_clears, clock, reset, !rsp_valid, "result strobe right after reset")

endmodule

bind displacement_to_normal_map dnm_checker u_dnm_checker (.*);
